FILE: rtl/dmc_pkg.sv
package dmc_pkg;

    localparam int ADDR_W = 16;
    localparam int LINE_OUT_W = 9;
    localparam int CNT_W = 32;
    localparam int CFG_DATA_W = 4;
    localparam int OFF_W = 3;
    localparam int IDX_W = 4;
    localparam int SHIFT_W = 5;

    localparam logic [OFF_W-1:0] OFF_MAX = 3'd4;
    localparam logic [OFF_W-1:0] OFF_RESET = 3'd0;
    localparam logic [IDX_W-1:0] IDX_RESET = 4'd9;

    localparam logic REG_OFFSET_BITS = 1'b0;
    localparam logic REG_INDEX_BITS = 1'b1;

    typedef logic [ADDR_W-1:0] t_tag;
    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_lookup_result;

endpackage

FILE: rtl/dmc_tag_mem.sv
module dmc_tag_mem #(
    parameter int DEPTH = 512,
    parameter int AW = 9,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    output logic          o_clearing
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          n_clearing;
    logic [AW-1:0] n_clr_addr;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_clearing = r_clearing;

endmodule

FILE: rtl/dmc_sat_counters.sv
module dmc_sat_counters (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dmc_pkg::t_lookup_result i_result,
    output dmc_pkg::t_count         o_hit_total,
    output dmc_pkg::t_count         o_miss_total
);

    dmc_pkg::t_count r_hits;
    dmc_pkg::t_count r_misses;
    dmc_pkg::t_count n_hits;
    dmc_pkg::t_count n_misses;

    always_comb begin
        n_hits = r_hits;
        n_misses = r_misses;
        if (i_result.valid) begin
            if (i_result.hit) begin
                if (r_hits != '1) begin
                    n_hits = r_hits + dmc_pkg::CNT_W'(1);
                end
            end else begin
                if (r_misses != '1) begin
                    n_misses = r_misses + dmc_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_misses <= '0;
        end else begin
            r_hits <= n_hits;
            r_misses <= n_misses;
        end
    end

    assign o_hit_total = r_hits;
    assign o_miss_total = r_misses;

endmodule

FILE: rtl/direct_mapped_cache_tag_check_core.sv
// Direct-mapped cache tag checker.
// Input channel: an address beat is taken at a rising edge where i_start is high
// and o_busy is low. The low offset bits are dropped, the next index bits pick a
// line, and the rest of the address is the tag.
// Result channel: o_done is high for exactly one cycle per address, after the
// r_s1_valid and r_done registers, with o_hit, o_line_index and the saturating
// o_hit_total and o_miss_total that already include this access.
// Throughput is one address per cycle while o_busy is low. The tag memory is read
// in the cycle after acceptance and written back at its end; an access to the line
// written in that same cycle takes the new entry from a bypass register.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0: offset bits, 1: index bits) at once; write only while no access is in flight.
// Reset: control state and counters clear, then a sweep over all NUM_LINES lines
// clears every valid bit while o_busy stays high. Configuration writes are taken
// during the sweep.
// The receiver cannot stall; every result is shown once and must be taken.
module direct_mapped_cache_tag_check_core #(
    parameter int NUM_LINES = 512,
    parameter int ADDRESS_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [dmc_pkg::ADDR_W-1:0]          i_address,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_done,
    output logic                                o_hit,
    output logic [dmc_pkg::LINE_OUT_W-1:0]      o_line_index,
    output dmc_pkg::t_count                     o_hit_total,
    output dmc_pkg::t_count                     o_miss_total
);

    localparam int LINE_AW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int IDX_LIMIT = $clog2(NUM_LINES + 1) - 1;
    localparam int ENTRY_W = dmc_pkg::ADDR_W + 1;
    localparam logic [dmc_pkg::IDX_W-1:0] IDX_LIMIT_V = dmc_pkg::IDX_W'(IDX_LIMIT);
    localparam logic [5:0] ABITS_V = 6'(ADDRESS_BITS);
    localparam logic [dmc_pkg::ADDR_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= dmc_pkg::ADDR_W) ? '1 : dmc_pkg::ADDR_W'((1 << ADDRESS_BITS) - 1);

    logic [dmc_pkg::OFF_W-1:0]  r_offset_bits;
    logic [dmc_pkg::IDX_W-1:0]  r_index_bits;

    logic [dmc_pkg::OFF_W-1:0]  off_eff;
    logic [dmc_pkg::IDX_W-1:0]  idx_lim;
    logic [dmc_pkg::IDX_W-1:0]  idx_eff;
    logic [5:0]                 idx_room;
    logic [dmc_pkg::ADDR_W-1:0] addr_m;
    logic [dmc_pkg::ADDR_W-1:0] line_full;
    logic [LINE_AW-1:0]         line;
    dmc_pkg::t_tag              tag;
    logic                       accept;

    logic                           r_s1_valid;
    logic [LINE_AW-1:0]             r_s1_line;
    logic [dmc_pkg::LINE_OUT_W-1:0] r_s1_line_out;
    dmc_pkg::t_tag                  r_s1_tag;
    logic                           r_fwd;
    dmc_pkg::t_tag                  r_fwd_tag;

    logic [ENTRY_W-1:0]  rdata;
    logic                clearing;
    logic                eff_valid;
    dmc_pkg::t_tag       eff_tag;
    logic                hit;
    dmc_pkg::t_lookup_result result;

    logic                           r_done;
    logic                           r_hit;
    logic [dmc_pkg::LINE_OUT_W-1:0] r_line_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= dmc_pkg::OFF_RESET;
            r_index_bits <= dmc_pkg::IDX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dmc_pkg::REG_OFFSET_BITS: r_offset_bits <= i_cfg_data[dmc_pkg::OFF_W-1:0];
                dmc_pkg::REG_INDEX_BITS: r_index_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        off_eff = (r_offset_bits > dmc_pkg::OFF_MAX) ? dmc_pkg::OFF_MAX : r_offset_bits;
        idx_lim = (r_index_bits > IDX_LIMIT_V) ? IDX_LIMIT_V : r_index_bits;
        idx_room = ABITS_V - 6'(off_eff);
        idx_eff = (6'(idx_lim) > idx_room) ? idx_room[dmc_pkg::IDX_W-1:0] : idx_lim;
        addr_m = i_address & ADDR_MASK;
        line_full = (addr_m >> off_eff) & ~({dmc_pkg::ADDR_W{1'b1}} << idx_eff);
        line = line_full[LINE_AW-1:0];
        tag = addr_m >> (dmc_pkg::SHIFT_W'(off_eff) + dmc_pkg::SHIFT_W'(idx_eff));
    end

    assign accept = i_start && !clearing;
    assign o_busy = clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_fwd <= accept && r_s1_valid && (r_s1_line == line);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_line <= line;
            r_s1_line_out <= line_full[dmc_pkg::LINE_OUT_W-1:0];
            r_s1_tag <= tag;
        end
        r_fwd_tag <= r_s1_tag;
    end

    dmc_tag_mem #(
        .DEPTH (NUM_LINES),
        .AW    (LINE_AW),
        .DW    (ENTRY_W)
    ) u_tag_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_raddr    (line),
        .o_rdata    (rdata),
        .i_we       (r_s1_valid),
        .i_waddr    (r_s1_line),
        .i_wdata    ({1'b1, r_s1_tag}),
        .o_clearing (clearing)
    );

    always_comb begin
        eff_valid = r_fwd ? 1'b1 : rdata[ENTRY_W-1];
        eff_tag = r_fwd ? r_fwd_tag : rdata[dmc_pkg::ADDR_W-1:0];
        hit = eff_valid && (eff_tag == r_s1_tag);
        result.valid = r_s1_valid;
        result.hit = hit;
    end

    dmc_sat_counters u_counters (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (result),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_hit <= hit;
            r_line_out <= r_s1_line_out;
        end
    end

    assign o_done = r_done;
    assign o_hit = r_hit;
    assign o_line_index = r_line_out;

    a_stage_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(i_start && !o_busy))
        else $error("lookup stage active without an accepted address");

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |=> !r_s1_valid)
        else $error("address entered the pipeline during the clearing sweep");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_hit_total != '0))
        else $error("hit reported with a zero hit total");

    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_miss_total != '0))
        else $error("miss reported with a zero miss total");

    a_fwd_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(r_s1_valid))
        else $error("bypass taken without a write in the previous cycle");

endmodule
